>>> design/xray_gray_window_level_mapper_unit_defines.svh
// assertion macros for the gray window/level mapper checker
// no dependencies; included by the checker file
`ifndef XRAY_GRAY_WINDOW_LEVEL_MAPPER_UNIT_DEFINES_SVH
`define XRAY_GRAY_WINDOW_LEVEL_MAPPER_UNIT_DEFINES_SVH

// checked only while out of reset
`define XWL_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("xwl assertion failed");

// checked at every edge, reset included
`define XWL_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("xwl assertion failed");

`endif

>>> design/xwl_pkg.sv
// shared types and constants for the gray window/level mapper
// no dependencies; imported by every module of the block
package xwl_pkg;

	localparam int SAMPLE_W = 16;
	localparam int OFF_W    = 17;
	localparam int ADJ_W    = 18;
	localparam int LEVEL_W  = 8;
	localparam int NUM_W    = SAMPLE_W + LEVEL_W;
	localparam int ADDR_W   = 5;
	localparam int DATA_W   = 32;
	localparam int IDX_W    = 3;

	localparam logic [LEVEL_W-1:0]  LEVEL_MAX   = 8'd255;
	localparam logic [SAMPLE_W-1:0] WINDOW_FULL = 16'hFFFF;

	localparam logic [IDX_W-1:0] REG_WINDOW_LOW    = 3'd0;
	localparam logic [IDX_W-1:0] REG_WINDOW_HIGH   = 3'd1;
	localparam logic [IDX_W-1:0] REG_BACKGROUND    = 3'd2;
	localparam logic [IDX_W-1:0] REG_BRIGHT_OFFSET = 3'd3;
	localparam logic [IDX_W-1:0] REG_INVERT        = 3'd4;
	localparam logic [IDX_W-1:0] REG_BORDER_TOP    = 3'd5;
	localparam logic [IDX_W-1:0] REG_BORDER_BOTTOM = 3'd6;
	localparam logic [IDX_W-1:0] REG_LINE_WIDTH    = 3'd7;

	typedef struct packed {
		logic [SAMPLE_W-1:0] window_low;
		logic [SAMPLE_W-1:0] window_high;
		logic [SAMPLE_W-1:0] background_level;
		logic [OFF_W-1:0]    brightness_offset;
		logic                invert_enable;
	} cfg_t;

	typedef struct packed {
		logic border;
		logic frame_end;
	} pix_tag_t;

endpackage

>>> design/xwl_regs.sv
// configuration register file with apb-style write/read access
// depends on xwl_pkg
module xwl_regs import xwl_pkg::*; #(
	parameter int MAX_COLUMNS = 4096,
	localparam int LW_W = $clog2(MAX_COLUMNS + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output cfg_t              cfg,
	output logic [LW_W-1:0]   border_top,
	output logic [LW_W-1:0]   border_bottom,
	output logic [LW_W-1:0]   line_width
);

	cfg_t            cfg_q;
	logic [LW_W-1:0] border_top_q;
	logic [LW_W-1:0] border_bottom_q;
	logic [LW_W-1:0] line_width_q;
	logic [IDX_W-1:0] idx;
	logic            wr;

	assign idx = paddr[ADDR_W-1:2];
	assign wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_low        <= '0;
			cfg_q.window_high       <= WINDOW_FULL;
			cfg_q.background_level  <= '0;
			cfg_q.brightness_offset <= '0;
			cfg_q.invert_enable     <= 1'b0;
			border_top_q            <= '0;
			border_bottom_q         <= '0;
			line_width_q            <= LW_W'(MAX_COLUMNS);
		end else if (wr) begin
			case (idx)
				REG_WINDOW_LOW:    cfg_q.window_low        <= pwdata[SAMPLE_W-1:0];
				REG_WINDOW_HIGH:   cfg_q.window_high       <= pwdata[SAMPLE_W-1:0];
				REG_BACKGROUND:    cfg_q.background_level  <= pwdata[SAMPLE_W-1:0];
				REG_BRIGHT_OFFSET: cfg_q.brightness_offset <= pwdata[OFF_W-1:0];
				REG_INVERT:        cfg_q.invert_enable     <= pwdata[0];
				REG_BORDER_TOP:    border_top_q            <= pwdata[LW_W-1:0];
				REG_BORDER_BOTTOM: border_bottom_q         <= pwdata[LW_W-1:0];
				REG_LINE_WIDTH:    line_width_q            <= pwdata[LW_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_WINDOW_LOW:    prdata = DATA_W'(cfg_q.window_low);
			REG_WINDOW_HIGH:   prdata = DATA_W'(cfg_q.window_high);
			REG_BACKGROUND:    prdata = DATA_W'(cfg_q.background_level);
			REG_BRIGHT_OFFSET: prdata = DATA_W'(cfg_q.brightness_offset);
			REG_INVERT:        prdata = DATA_W'(cfg_q.invert_enable);
			REG_BORDER_TOP:    prdata = DATA_W'(border_top_q);
			REG_BORDER_BOTTOM: prdata = DATA_W'(border_bottom_q);
			REG_LINE_WIDTH:    prdata = DATA_W'(line_width_q);
			default:           prdata = '0;
		endcase
	end

	assign cfg           = cfg_q;
	assign border_top    = border_top_q;
	assign border_bottom = border_bottom_q;
	assign line_width    = line_width_q;

endmodule

>>> design/xwl_front.sv
// front pipeline: brightness offset and border test, window clamp/invert, times-255
// depends on xwl_pkg; feeds the divider
module xwl_front import xwl_pkg::*; #(
	parameter int MAX_COLUMNS = 4096,
	localparam int COL_W = $clog2(MAX_COLUMNS),
	localparam int LW_W  = $clog2(MAX_COLUMNS + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  logic [LW_W-1:0]     border_top,
	input  logic [LW_W-1:0]     border_bottom,
	input  logic [LW_W-1:0]     line_width,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [SAMPLE_W-1:0] sample,
	input  logic [COL_W-1:0]    column,
	input  logic                frame_end,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [NUM_W-1:0]    num,
	output pix_tag_t            tag
);

	logic                v_s1, v_s2, v_s3;
	logic                rdy_s1, rdy_s2, rdy_s3;
	logic [ADJ_W-1:0]    g_s1;
	logic [SAMPLE_W-1:0] pos_s2;
	logic [NUM_W-1:0]    num_s3;
	pix_tag_t            tag_s1, tag_s2, tag_s3;

	logic signed [ADJ_W-1:0]  g_adj;
	logic [LW_W:0]            col_x;
	logic signed [LW_W:0]     bot_lim;
	logic                     border_hit;
	logic signed [ADJ_W-1:0]  lo_x, hi_x;
	logic [SAMPLE_W-1:0]      g_clamp;
	logic [SAMPLE_W-1:0]      pos;

	assign rdy_s3   = !v_s3 || out_ready;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// stage 1: offset below background, border band test
	always_comb begin
		if (sample < cfg.background_level) begin
			g_adj = $signed({2'b00, sample}) +
				$signed({cfg.brightness_offset[OFF_W-1], cfg.brightness_offset});
		end else begin
			g_adj = $signed({2'b00, sample});
		end
		col_x      = {{(LW_W + 1 - COL_W){1'b0}}, column};
		bot_lim    = $signed({1'b0, line_width}) - $signed({1'b0, border_bottom});
		border_hit = (col_x < {1'b0, border_top}) || ($signed(col_x) > bot_lim);
	end

	// stage 2: clamp into window, invert, offset from window start (from window end when inverted)
	always_comb begin
		lo_x = $signed({2'b00, cfg.window_low});
		hi_x = $signed({2'b00, cfg.window_high});
		if ($signed(g_s1) < lo_x) begin
			g_clamp = cfg.window_low;
		end else if ($signed(g_s1) > hi_x) begin
			g_clamp = cfg.window_high;
		end else begin
			g_clamp = g_s1[SAMPLE_W-1:0];
		end
		if (cfg.invert_enable) begin
			pos = cfg.window_high - g_clamp;
		end else begin
			pos = g_clamp - cfg.window_low;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			g_s1             <= g_adj;
			tag_s1.border    <= border_hit;
			tag_s1.frame_end <= frame_end;
		end
		if (rdy_s2 && v_s1) begin
			pos_s2 <= pos;
			tag_s2 <= tag_s1;
		end
		if (rdy_s3 && v_s2) begin
			// pos * 255
			num_s3 <= {pos_s2, {LEVEL_W{1'b0}}} - NUM_W'(pos_s2);
			tag_s3 <= tag_s2;
		end
	end

	assign out_valid = v_s3;
	assign num       = num_s3;
	assign tag       = tag_s3;

endmodule

>>> design/xwl_div.sv
// pipelined restoring divider, one quotient bit per stage
// depends on xwl_pkg; divides pos*255 by the window span
module xwl_div import xwl_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [SAMPLE_W-1:0] span,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [NUM_W-1:0]    num,
	input  pix_tag_t            in_tag,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [LEVEL_W-1:0]  quot,
	output pix_tag_t            out_tag
);

	logic                v_s   [LEVEL_W];
	logic [NUM_W-1:0]    rem_s [LEVEL_W];
	logic [LEVEL_W-1:0]  q_s   [LEVEL_W];
	pix_tag_t            tag_s [LEVEL_W];
	logic                rdy   [LEVEL_W+1];

	assign rdy[LEVEL_W] = out_ready;
	assign in_ready     = rdy[0];

	for (genvar j = 0; j < LEVEL_W; j++) begin : g_stage
		logic                v_in;
		logic [NUM_W-1:0]    rem_in;
		logic [LEVEL_W-1:0]  q_in;
		pix_tag_t            tag_in;
		logic [NUM_W-1:0]    dsor;
		logic                take;

		if (j == 0) begin : g_first
			assign v_in   = in_valid;
			assign rem_in = num;
			assign q_in   = '0;
			assign tag_in = in_tag;
		end else begin : g_next
			assign v_in   = v_s[j-1];
			assign rem_in = rem_s[j-1];
			assign q_in   = q_s[j-1];
			assign tag_in = tag_s[j-1];
		end

		assign rdy[j] = !v_s[j] || rdy[j+1];
		assign dsor   = NUM_W'(span) << (LEVEL_W - 1 - j);
		assign take   = rem_in >= dsor;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (rdy[j]) begin
				v_s[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[j] && v_in) begin
				rem_s[j] <= take ? rem_in - dsor : rem_in;
				q_s[j]   <= {q_in[LEVEL_W-2:0], take};
				tag_s[j] <= tag_in;
			end
		end
	end

	assign out_valid = v_s[LEVEL_W-1];
	assign quot      = q_s[LEVEL_W-1];
	assign out_tag   = tag_s[LEVEL_W-1];

endmodule

>>> design/xray_gray_window_level_mapper_unit.sv
// X-ray gray window/level mapper, one pixel per cycle while out_stall is low.
// Input channel: sample, column, frame_end with in_valid/in_stall; a transfer
// happens on a rising edge with in_valid high and in_stall low.
// Output channel: level, frame_end_out with out_valid/out_stall, same rule.
// Registers sit behind an apb-style port at byte address 4*index; pready is
// always high and reads return the stored value. Write them only while no
// pixel is in flight.
// From input transfer to out_valid a pixel passes 3 front stages, 8 divider
// stages and 1 output register. Throughput: one pixel per cycle while out_stall
// is low, set by the 8-stage divider that produces one quotient bit per stage.
// Every stage has its own valid bit and moves when the stage after it is
// free, so bubbles close up; in_stall rises only once all 12 stages hold data
// behind a stalled output. A stalled result holds steady on the output.
// Reset clears all valid bits and loads the register defaults: window
// 0..65535, no offset, no invert, no border, line width MAX_COLUMNS.
// depends on xwl_pkg, xwl_regs, xwl_front, xwl_div
module xray_gray_window_level_mapper_unit import xwl_pkg::*; #(
	parameter int MAX_COLUMNS = 4096,
	localparam int COL_W = $clog2(MAX_COLUMNS)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]   prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [SAMPLE_W-1:0] sample,
	input  logic [COL_W-1:0]    column,
	input  logic                frame_end,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [LEVEL_W-1:0]  level,
	output logic                frame_end_out
);

	localparam int LW_W = $clog2(MAX_COLUMNS + 1);

	cfg_t                cfg;
	logic [LW_W-1:0]     border_top;
	logic [LW_W-1:0]     border_bottom;
	logic [LW_W-1:0]     line_width;
	logic                front_ready;
	logic                front_valid;
	logic [NUM_W-1:0]    front_num;
	pix_tag_t            front_tag;
	logic                div_ready;
	logic                div_valid;
	logic [LEVEL_W-1:0]  div_quot;
	pix_tag_t            div_tag;
	logic [SAMPLE_W-1:0] span;
	logic                out_free;
	logic [LEVEL_W-1:0]  level_d;
	logic                out_valid_q;
	logic [LEVEL_W-1:0]  level_q;
	logic                frame_end_q;

	assign pready = 1'b1;

	xwl_regs #(.MAX_COLUMNS(MAX_COLUMNS)) u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.cfg           (cfg),
		.border_top    (border_top),
		.border_bottom (border_bottom),
		.line_width    (line_width)
	);

	xwl_front #(.MAX_COLUMNS(MAX_COLUMNS)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.border_top    (border_top),
		.border_bottom (border_bottom),
		.line_width    (line_width),
		.in_valid      (in_valid),
		.in_ready      (front_ready),
		.sample        (sample),
		.column        (column),
		.frame_end     (frame_end),
		.out_valid     (front_valid),
		.out_ready     (div_ready),
		.num           (front_num),
		.tag           (front_tag)
	);

	assign span = cfg.window_high - cfg.window_low;

	xwl_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.span      (span),
		.in_valid  (front_valid),
		.in_ready  (div_ready),
		.num       (front_num),
		.in_tag    (front_tag),
		.out_valid (div_valid),
		.out_ready (out_free),
		.quot      (div_quot),
		.out_tag   (div_tag)
	);

	assign in_stall = !front_ready;
	assign out_free = !out_valid_q || !out_stall;

	// border overrides everything, empty window gives black
	always_comb begin
		if (div_tag.border) begin
			level_d = cfg.invert_enable ? LEVEL_MAX : '0;
		end else if (cfg.window_high > cfg.window_low) begin
			level_d = div_quot;
		end else begin
			level_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && div_valid) begin
			level_q     <= level_d;
			frame_end_q <= div_tag.frame_end;
		end
	end

	assign out_valid     = out_valid_q;
	assign level         = level_q;
	assign frame_end_out = frame_end_q;

endmodule

>>> design/xwl_checker.sv
// port-level checker for the gray window/level mapper, bound to the top level
// depends on xwl_pkg and xray_gray_window_level_mapper_unit_defines.svh
`include "xray_gray_window_level_mapper_unit_defines.svh"

module xwl_checker import xwl_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                psel,
	input logic                penable,
	input logic                pwrite,
	input logic [ADDR_W-1:0]   paddr,
	input logic [DATA_W-1:0]   pwdata,
	input logic [DATA_W-1:0]   prdata,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input logic [LEVEL_W-1:0]  level,
	input logic                frame_end_out
);

	logic wr_high;
	logic rd_high;

	assign wr_high = psel && penable && pwrite && paddr[ADDR_W-1:2] == REG_WINDOW_HIGH;
	assign rd_high = psel && penable && !pwrite && paddr[ADDR_W-1:2] == REG_WINDOW_HIGH;

	// stalled result stays offered
	`XWL_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid)
	// stalled result keeps its payload
	`XWL_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(level) && $stable(frame_end_out))
	// with no result waiting every stage drains, so input is never stalled
	`XWL_ASSERT(a_no_stall_when_empty, !out_valid |-> !in_stall)
	// reset held over an edge empties the pipeline
	`XWL_ASSERT_ALWAYS(a_reset_empty, !arst_n ##1 !arst_n |-> !out_valid && !in_stall)
	// window high write followed by a read of it returns the written value
	`XWL_ASSERT(a_readback, wr_high ##2 rd_high |-> prdata[SAMPLE_W-1:0] == $past(pwdata[SAMPLE_W-1:0], 2))

endmodule

bind xray_gray_window_level_mapper_unit xwl_checker u_xwl_checker (.*);
